[src/ffp_pkg.sv]
`default_nettype none

package ffp_pkg;

  // Partition table geometry
  localparam int NUM_PARTS = 4;
  localparam int IDX_W     = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CNT_W     = $clog2(NUM_PARTS + 1);

  // Fixed field widths
  localparam int ID_W     = 16;
  localparam int SIZE_W   = 16;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int PIDX_W   = 2;
  localparam int CFG_IX_W = 3;
  localparam int CFG_D_W  = 16;
  localparam int PIU_W    = 3;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXCEED    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_TOTAL_CAP    = 3'd0;
  localparam logic [CFG_IX_W-1:0] CFG_PARTS_IN_USE = 3'd1;
  localparam logic [CFG_IX_W-1:0] CFG_SIZE_BASE    = 3'd2;

  // One entry of the partition table memory
  typedef struct packed {
    logic [ID_W-1:0]   owner;
    logic [SIZE_W-1:0] used;
  } ffp_entry_t;

  localparam int ENTRY_W = $bits(ffp_entry_t);

endpackage

`default_nettype wire

[src/fixed_partition_first_fit.sv]
`default_nettype none

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    opcode, process_id, request_size, entry_index
// out_     output     out_valid / out_ready  status, partition_index, occupied, owner_id,
//                                            used_size
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An allocate or free probes partitions in order from index 0, 1 .. NUM_PARTS of them, each
// probe an address state (RD) then a memory read seen in CMP; its result then loads from DONE.
// A read in range probes its one entry; errors and unknown opcodes go straight to DONE.
// Reset empties every partition at once through per-entry valid bits; no clearing pass.
// A result waiting on out_ready holds the output register; the next transaction may be
// accepted and worked on meanwhile, and stalls only when it needs the output register.

module fixed_partition_first_fit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ffp_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [ffp_pkg::ID_W-1:0]      in_process_id,
  input  wire logic [ffp_pkg::SIZE_W-1:0]    in_request_size,
  input  wire logic [ffp_pkg::PIDX_W-1:0]    in_entry_index,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [ffp_pkg::STAT_W-1:0]    out_status,
  output logic      [ffp_pkg::PIDX_W-1:0]    out_partition_index,
  output logic                               out_occupied,
  output logic      [ffp_pkg::ID_W-1:0]      out_owner_id,
  output logic      [ffp_pkg::SIZE_W-1:0]    out_used_size,
  // configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ffp_pkg::CFG_IX_W-1:0]  cfg_index,
  input  wire logic [ffp_pkg::CFG_D_W-1:0]   cfg_data
);

  import ffp_pkg::*;

  // Sequencer: RD presents the probe address, CMP sees the entry and decides
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [SIZE_W-1:0] total_cap_r;
  logic [PIU_W-1:0]  parts_in_use_r;
  logic [SIZE_W-1:0] part_size_r [NUM_PARTS];

  // Captured transaction
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ID_W-1:0]   pid_r, pid_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;

  // Result waiting for the output register
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [PIDX_W-1:0] res_index_r, res_index_nxt;
  logic              res_occ_r, res_occ_nxt;
  logic [ID_W-1:0]   res_owner_r, res_owner_nxt;
  logic [SIZE_W-1:0] res_used_r, res_used_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [PIDX_W-1:0] out_index_r;
  logic              out_occ_r;
  logic [ID_W-1:0]   out_owner_r;
  logic [SIZE_W-1:0] out_used_r;
  logic              out_load;

  // Owner valid bits: an entry not yet written reads as empty
  logic [NUM_PARTS-1:0] valid_r, valid_nxt;

  // Table memory port
  logic       ram_we;
  ffp_entry_t ram_wdata;
  ffp_entry_t ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic [CNT_W-1:0]  search_n;
  logic [ID_W-1:0]   cur_owner;
  logic              last_probe;
  logic              idx_outside;

  ffp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_PARTS),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr_r),
    .wdata(ram_wdata),
    .raddr(ptr_r),
    .rdata(ram_rdata_raw)
  );

  assign ram_rdata = ram_rdata_raw;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp the search count to the table depth
  assign search_n = (parts_in_use_r > PIU_W'(NUM_PARTS)) ? CNT_W'(NUM_PARTS)
                                                         : CNT_W'(parts_in_use_r);

  assign cur_owner   = valid_r[ptr_r] ? ram_rdata.owner : '0;
  assign last_probe  = (CNT_W'(ptr_r) + CNT_W'(1)) == count_r;
  assign idx_outside = ({1'b0, in_entry_index} >= (PIDX_W + 1)'(NUM_PARTS));

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pid_nxt        = pid_r;
    req_nxt        = req_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_occ_nxt    = res_occ_r;
    res_owner_nxt  = res_owner_r;
    res_used_nxt   = res_used_r;
    valid_nxt      = valid_r;
    ram_we         = 1'b0;
    ram_wdata      = '{owner: pid_r, used: req_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          pid_nxt        = in_process_id;
          req_nxt        = in_request_size;
          count_nxt      = search_n;
          ptr_nxt        = '0;
          res_status_nxt = ST_DONE;
          res_index_nxt  = '0;
          res_occ_nxt    = 1'b0;
          res_owner_nxt  = '0;
          res_used_nxt   = '0;
          state_nxt      = S_DONE;
          // Settle errors and trivial cases at acceptance; probe the table otherwise
          priority if (in_opcode == OP_ALLOC && in_request_size >= total_cap_r) begin
            res_status_nxt = ST_EXCEED;
          end else if (in_opcode == OP_ALLOC && search_n == '0) begin
            res_status_nxt = ST_NO_FIT;
          end else if (in_opcode == OP_FREE && search_n == '0) begin
            res_status_nxt = ST_NOT_FOUND;
          end else if (in_opcode == OP_ALLOC || in_opcode == OP_FREE) begin
            state_nxt = S_RD;
          end else if (in_opcode == OP_READ) begin
            res_index_nxt = in_entry_index;
            if (!idx_outside) begin
              ptr_nxt   = IDX_W'(in_entry_index);
              state_nxt = S_RD;
            end
          end else begin
            // unknown opcode: all-zero result
          end
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        state_nxt = S_DONE;
        priority if (op_r == OP_ALLOC) begin
          if (req_r < part_size_r[ptr_r] && cur_owner == '0) begin
            ram_we           = 1'b1;
            ram_wdata        = '{owner: pid_r, used: req_r};
            valid_nxt[ptr_r] = 1'b1;
            res_index_nxt    = PIDX_W'(ptr_r);
          end else if (last_probe) begin
            res_status_nxt = ST_NO_FIT;
          end else begin
            ptr_nxt   = ptr_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end else if (op_r == OP_FREE) begin
          if (cur_owner == pid_r) begin
            // keep the used size, drop the owner
            ram_we           = 1'b1;
            ram_wdata        = '{owner: '0, used: ram_rdata.used};
            valid_nxt[ptr_r] = 1'b1;
            res_index_nxt    = PIDX_W'(ptr_r);
          end else if (last_probe) begin
            res_status_nxt = ST_NOT_FOUND;
          end else begin
            ptr_nxt   = ptr_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          // read: an empty partition shows nothing
          if (cur_owner != '0) begin
            res_occ_nxt   = 1'b1;
            res_owner_nxt = cur_owner;
            res_used_nxt  = ram_rdata.used;
          end
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_cap_r    <= '1;
      parts_in_use_r <= PIU_W'(4);
      for (int i = 0; i < NUM_PARTS; i++) begin
        part_size_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TOTAL_CAP) begin
        total_cap_r <= cfg_data;
      end
      if (cfg_index == CFG_PARTS_IN_USE) begin
        parts_in_use_r <= cfg_data[PIU_W-1:0];
      end
      for (int i = 0; i < NUM_PARTS; i++) begin
        if (cfg_index == CFG_SIZE_BASE + CFG_IX_W'(i)) begin
          part_size_r[i] <= cfg_data;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pid_r        <= pid_nxt;
    req_r        <= req_nxt;
    count_r      <= count_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_occ_r    <= res_occ_nxt;
    res_owner_r  <= res_owner_nxt;
    res_used_r   <= res_used_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_occ_r    <= res_occ_r;
      out_owner_r  <= res_owner_r;
      out_used_r   <= res_used_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_partition_index = out_index_r;
  assign out_occupied        = out_occ_r;
  assign out_owner_id        = out_owner_r;
  assign out_used_size       = out_used_r;

endmodule

`default_nettype wire

[src/ffp_ram.sv]
`default_nettype none

module ffp_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 4,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
